@@ design/rpcf_pkg.sv @@
// ----------------------------------------------------------------------------
// rpcf_pkg: shared types and constants for the RGB pixel color filter
// Pixel structs, configuration codes, fixed-point weight tables and the
// types carried between pipeline stages.
// ----------------------------------------------------------------------------
`default_nettype none

package rpcf_pkg;

  localparam int CHANNEL_BITS = 8;
  localparam int WEIGHT_BITS  = 16;               // Q16 weights
  localparam int FRAC_BITS    = 16;
  localparam int PROD_W       = CHANNEL_BITS + WEIGHT_BITS;
  localparam int SUM_W        = PROD_W + 2;       // three products
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 8;
  localparam int MODE_W       = 3;
  localparam int TONE_W       = 2;
  localparam int TONE_OFS_W   = CHANNEL_BITS + 1;

  localparam logic [CHANNEL_BITS-1:0] CH_MAX    = {CHANNEL_BITS{1'b1}};
  localparam logic [CHANNEL_BITS-1:0] MAX_RESET = CH_MAX;

  typedef struct packed {
    logic [CHANNEL_BITS-1:0] red_in;
    logic [CHANNEL_BITS-1:0] green_in;
    logic [CHANNEL_BITS-1:0] blue_in;
  } pixel_in_t;

  typedef struct packed {
    logic [CHANNEL_BITS-1:0] red_out;
    logic [CHANNEL_BITS-1:0] green_out;
    logic [CHANNEL_BITS-1:0] blue_out;
  } pixel_out_t;

  typedef enum logic [MODE_W-1:0] {
    FM_PASS      = 3'd0,
    FM_GREY      = 3'd1,
    FM_NEGATIVE  = 3'd2,
    FM_SEPIA     = 3'd3,
    FM_TONE      = 3'd4,
    FM_THRESHOLD = 3'd5
  } filter_mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FILTER_MODE = 2'd0,
    CFG_TONE_SELECT = 2'd1,
    CFG_MAX_VALUE   = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [MODE_W-1:0]       filter_mode;
    logic [TONE_W-1:0]       tone_select;
    logic [CHANNEL_BITS-1:0] max_value;
  } cfg_t;

  // luma weights, truncated Q16
  localparam logic [WEIGHT_BITS-1:0] GREY_W [3] = '{16'd19588, 16'd38469, 16'd7471};

  // sepia matrix, rows are output channels
  localparam logic [WEIGHT_BITS-1:0] SEPIA_W [3][3] = '{
    '{16'd25756, 16'd50397, 16'd12386},
    '{16'd22872, 16'd44958, 16'd11010},
    '{16'd17826, 16'd34996, 16'd8585}
  };

  localparam logic signed [TONE_OFS_W-1:0] TONE_OFS [4][3] = '{
    '{ 9'sd0,    9'sd0,    9'sd0},
    '{ 9'sd91,  -9'sd99,  -9'sd14},
    '{-9'sd115, -9'sd86,  -9'sd23},
    '{-9'sd72,   9'sd75,  -9'sd77}
  };

  // stage 1 -> stage 2: pixel plus all weighted products
  // row 0 is luma, rows 1..3 are sepia red/green/blue
  typedef struct packed {
    pixel_in_t                       pixel;
    logic [3:0][2:0][PROD_W-1:0]     prod;
  } prod_t;

  // stage 2 -> stage 3: per-mode candidate channel values
  typedef struct packed {
    pixel_in_t                       pixel;
    logic [CHANNEL_BITS-1:0]         grey;
    logic [2:0][CHANNEL_BITS:0]      sepia;
    logic [2:0][CHANNEL_BITS-1:0]    neg;
    logic [2:0][CHANNEL_BITS-1:0]    tone;
    logic                            thr;
  } cand_t;

endpackage

`default_nettype wire

@@ design/rpcf_mult.sv @@
// ----------------------------------------------------------------------------
// rpcf_mult: product stage
// Multiplies each channel by its luma and sepia weights and registers the
// twelve products together with the pixel.
// ----------------------------------------------------------------------------
`default_nettype none

module rpcf_mult (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               valid_i,
  output logic                    ready_o,
  input  wire rpcf_pkg::pixel_in_t pixel_i,
  output logic                    valid_o,
  input  wire logic               ready_i,
  output rpcf_pkg::prod_t         prod_o
);
  import rpcf_pkg::*;

  logic [CHANNEL_BITS-1:0] chan [3];
  logic                    valid_q;
  prod_t                   prod_d, prod_q;

  assign chan[0] = pixel_i.red_in;
  assign chan[1] = pixel_i.green_in;
  assign chan[2] = pixel_i.blue_in;

  always_comb begin
    prod_d.pixel = pixel_i;
    for (int k = 0; k < 3; k++) begin
      prod_d.prod[0][k] = PROD_W'(GREY_W[k]) * PROD_W'(chan[k]);
      for (int r = 0; r < 3; r++) begin
        prod_d.prod[r+1][k] = PROD_W'(SEPIA_W[r][k]) * PROD_W'(chan[k]);
      end
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      prod_q <= prod_d;
    end
  end

  assign valid_o = valid_q;
  assign prod_o  = prod_q;

endmodule

`default_nettype wire

@@ design/rpcf_sum.sv @@
// ----------------------------------------------------------------------------
// rpcf_sum: sum stage
// Adds the weighted products and drops the Q16 fraction; also forms the
// negative, tone and threshold candidates from the pixel.
// ----------------------------------------------------------------------------
`default_nettype none

module rpcf_sum (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire rpcf_pkg::cfg_t   cfg_i,
  input  wire logic             valid_i,
  output logic                  ready_o,
  input  wire rpcf_pkg::prod_t  prod_i,
  output logic                  valid_o,
  input  wire logic             ready_i,
  output rpcf_pkg::cand_t       cand_o
);
  import rpcf_pkg::*;

  logic [CHANNEL_BITS-1:0]        chan [3];
  logic [SUM_W-1:0]               sum  [4];
  logic signed [CHANNEL_BITS+1:0] tsum [3];
  logic                           valid_q;
  cand_t                          cand_d, cand_q;

  assign chan[0] = prod_i.pixel.red_in;
  assign chan[1] = prod_i.pixel.green_in;
  assign chan[2] = prod_i.pixel.blue_in;

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      sum[r] = SUM_W'(prod_i.prod[r][0]) + SUM_W'(prod_i.prod[r][1])
             + SUM_W'(prod_i.prod[r][2]);
    end
    for (int k = 0; k < 3; k++) begin
      tsum[k] = $signed({2'b00, chan[k]})
              + (CHANNEL_BITS+2)'(TONE_OFS[cfg_i.tone_select][k]);
    end
  end

  always_comb begin
    cand_d.pixel = prod_i.pixel;
    cand_d.grey  = sum[0][FRAC_BITS +: CHANNEL_BITS];
    // largest channel above 127 is the same as any channel's top bit set
    cand_d.thr   = chan[0][CHANNEL_BITS-1] | chan[1][CHANNEL_BITS-1]
                 | chan[2][CHANNEL_BITS-1];
    for (int k = 0; k < 3; k++) begin
      cand_d.sepia[k] = sum[k+1][FRAC_BITS +: CHANNEL_BITS+1];
      cand_d.neg[k]   = (chan[k] >= cfg_i.max_value) ? '0 : cfg_i.max_value - chan[k];
      if (tsum[k] <= 0) begin
        cand_d.tone[k] = '0;
      end else if (tsum[k] >= $signed({2'b00, CH_MAX})) begin
        cand_d.tone[k] = CH_MAX;
      end else begin
        cand_d.tone[k] = tsum[k][CHANNEL_BITS-1:0];
      end
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      cand_q <= cand_d;
    end
  end

  assign valid_o = valid_q;
  assign cand_o  = cand_q;

endmodule

`default_nettype wire

@@ design/rpcf_select.sv @@
// ----------------------------------------------------------------------------
// rpcf_select: output stage
// Saturates the sepia sums, picks the result for the active mode and holds
// it in the output register until the transfer completes.
// ----------------------------------------------------------------------------
`default_nettype none

module rpcf_select (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire rpcf_pkg::cfg_t   cfg_i,
  input  wire logic             valid_i,
  output logic                  ready_o,
  input  wire rpcf_pkg::cand_t  cand_i,
  output logic                  valid_o,
  input  wire logic             ready_i,
  output rpcf_pkg::pixel_out_t  pixel_o
);
  import rpcf_pkg::*;

  logic [CHANNEL_BITS-1:0] sep [3];
  logic [CHANNEL_BITS-1:0] thr_val;
  logic                    valid_q;
  pixel_out_t              pixel_d, pixel_q;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sep[k] = (cand_i.sepia[k] >= {1'b0, cfg_i.max_value}) ? cfg_i.max_value
                                                            : cand_i.sepia[k][CHANNEL_BITS-1:0];
    end
    thr_val = cand_i.thr ? CH_MAX : '0;
  end

  always_comb begin
    case (cfg_i.filter_mode)
      FM_GREY: begin
        pixel_d = '{cand_i.grey, cand_i.grey, cand_i.grey};
      end
      FM_NEGATIVE: begin
        pixel_d = '{cand_i.neg[0], cand_i.neg[1], cand_i.neg[2]};
      end
      FM_SEPIA: begin
        pixel_d = '{sep[0], sep[1], sep[2]};
      end
      FM_TONE: begin
        pixel_d = '{cand_i.tone[0], cand_i.tone[1], cand_i.tone[2]};
      end
      FM_THRESHOLD: begin
        pixel_d = '{thr_val, thr_val, thr_val};
      end
      default: begin
        // pass-through, unused codes included
        pixel_d = '{cand_i.pixel.red_in, cand_i.pixel.green_in, cand_i.pixel.blue_in};
      end
    endcase
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      pixel_q <= pixel_d;
    end
  end

  assign valid_o = valid_q;
  assign pixel_o = pixel_q;

endmodule

`default_nettype wire

@@ design/rgb_pixel_color_filter.sv @@
// Stages in order: product, sum, select; each one registers its result.
// Throughput: one pixel per cycle while the output is not stalled; each stage refills as soon as it empties.
// Stall on the output backs up stage by stage; empty stages still accept.
// Reset clears all stage valid bits; mode resets to pass-through, tone
// select to 0 and max value to 255.
// ----------------------------------------------------------------------------
// rgb_pixel_color_filter: point filter on RGB pixels
// Pass, grey, negative, sepia, tone and threshold modes, selected by the
// configuration registers, over a three-stage pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb_pixel_color_filter (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 cfg_we_i,
  input  wire logic [rpcf_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  wire logic [rpcf_pkg::CFG_DATA_W-1:0]      cfg_wdata_i,
  input  wire logic                                 in_valid_i,
  output logic                                      in_stall_o,
  input  wire rpcf_pkg::pixel_in_t                  in_pixel_i,
  output logic                                      out_valid_o,
  input  wire logic                                 out_stall_i,
  output rpcf_pkg::pixel_out_t                      out_pixel_o
);
  import rpcf_pkg::*;

  cfg_t  cfg_q;
  logic  s1_ready, s1_valid, s2_ready, s2_valid, s3_ready;
  prod_t s1_prod;
  cand_t s2_cand;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.filter_mode <= FM_PASS;
      cfg_q.tone_select <= '0;
      cfg_q.max_value   <= MAX_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_FILTER_MODE: cfg_q.filter_mode <= cfg_wdata_i[MODE_W-1:0];
        CFG_TONE_SELECT: cfg_q.tone_select <= cfg_wdata_i[TONE_W-1:0];
        CFG_MAX_VALUE:   cfg_q.max_value   <= cfg_wdata_i[CHANNEL_BITS-1:0];
        default: ;
      endcase
    end
  end

  rpcf_mult u_mult (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .ready_o (s1_ready),
    .pixel_i (in_pixel_i),
    .valid_o (s1_valid),
    .ready_i (s2_ready),
    .prod_o  (s1_prod)
  );

  rpcf_sum u_sum (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .valid_i (s1_valid),
    .ready_o (s2_ready),
    .prod_i  (s1_prod),
    .valid_o (s2_valid),
    .ready_i (s3_ready),
    .cand_o  (s2_cand)
  );

  rpcf_select u_select (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .valid_i (s2_valid),
    .ready_o (s3_ready),
    .cand_i  (s2_cand),
    .valid_o (out_valid_o),
    .ready_i (!out_stall_i),
    .pixel_o (out_pixel_o)
  );

  assign in_stall_o = !s1_ready;

endmodule

`default_nettype wire

@@ design/rpcf_checker.sv @@
// ----------------------------------------------------------------------------
// rpcf_checker: port-level checks for the RGB pixel color filter
// Tracks the configuration writes and checks output pixels against the
// properties of the active mode.
// ----------------------------------------------------------------------------
`default_nettype none

module rpcf_checker (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 cfg_we_i,
  input  wire logic [rpcf_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  wire logic [rpcf_pkg::CFG_DATA_W-1:0]      cfg_wdata_i,
  input  wire logic                                 in_valid_i,
  input  wire logic                                 in_stall_o,
  input  wire rpcf_pkg::pixel_in_t                  in_pixel_i,
  input  wire logic                                 out_valid_o,
  input  wire logic                                 out_stall_i,
  input  wire rpcf_pkg::pixel_out_t                 out_pixel_o
);
  import rpcf_pkg::*;

  logic [MODE_W-1:0]       mode_q;
  logic [CHANNEL_BITS-1:0] max_q;
  logic                    in_seen;
  logic                    out_seen;
  logic [2:0]              inflight_d, inflight_q;

  assign in_seen    = in_valid_i && !in_stall_o;
  assign out_seen   = out_valid_o && !out_stall_i;
  assign inflight_d = inflight_q + 3'(in_seen) - 3'(out_seen);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= FM_PASS;
      max_q  <= MAX_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_FILTER_MODE: mode_q <= cfg_wdata_i[MODE_W-1:0];
        CFG_MAX_VALUE:   max_q  <= cfg_wdata_i[CHANNEL_BITS-1:0];
        default: ;
      endcase
    end
  end

  // pixels taken in and not yet handed on
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= '0;
    end else begin
      inflight_q <= inflight_d;
    end
  end

  // a held result keeps its value until transferred
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_pixel_o))
    else $error("output pixel changed while stalled");

  // no output can appear without an earlier input transfer
  a_no_early_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (inflight_q != '0))
    else $error("unexpected output");

  a_grey_equal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (mode_q == FM_GREY) |->
    (out_pixel_o.red_out == out_pixel_o.green_out) &&
    (out_pixel_o.green_out == out_pixel_o.blue_out))
    else $error("grey output channels differ");

  a_thr_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (mode_q == FM_THRESHOLD) |->
    (out_pixel_o.red_out == out_pixel_o.green_out) &&
    (out_pixel_o.green_out == out_pixel_o.blue_out) &&
    ((out_pixel_o.red_out == '0) || (out_pixel_o.red_out == CH_MAX)))
    else $error("threshold output not black or white");

  a_sat_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ((mode_q == FM_NEGATIVE) || (mode_q == FM_SEPIA)) |->
    (out_pixel_o.red_out <= max_q) && (out_pixel_o.green_out <= max_q) &&
    (out_pixel_o.blue_out <= max_q))
    else $error("channel above max value");

endmodule

bind rgb_pixel_color_filter rpcf_checker u_rpcf_checker (.*);

`default_nettype wire

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench: RGB pixel color filter
// Drives pixel transfers in bursts under random output stalls, predicts each
// filtered pixel from a local copy of the configuration and compares every
// output transfer field by field, in order. Directed corners per filter mode,
// then random configuration phases with random and biased pixels.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  import rpcf_pkg::*;

  localparam logic [MODE_W-1:0] MODE_SPARE_A = 3'd6;
  localparam logic [MODE_W-1:0] MODE_SPARE_B = 3'd7;
  localparam int PIPE_DEPTH   = 3;
  localparam int RANDOM_ITEMS = 1600;
  localparam int MAX_REPORTS  = 40;

  // Q16 weights: luma truncated, sepia rows rounded
  localparam int LUMA_K [3] = '{19588, 38469, 7471};
  localparam int SEPIA_K [3][3] = '{
    '{25756, 50397, 12386},
    '{22872, 44958, 11010},
    '{17826, 34996, 8585}
  };
  localparam int TONE_SHIFT [4][3] = '{
    '{0, 0, 0},
    '{91, -99, -14},
    '{-115, -86, -23},
    '{-72, 75, -77}
  };

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i   = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_stall_o;
  pixel_in_t             in_pixel_i  = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  pixel_out_t            out_pixel_o;

  // local copy of the configuration registers
  logic [MODE_W-1:0]       mode_q = 3'd0;
  logic [TONE_W-1:0]       tone_q = 2'd0;
  logic [CHANNEL_BITS-1:0] max_q  = 8'd255;

  pixel_in_t  send_queue[$];
  pixel_out_t pending_pixels[$];
  pixel_out_t want_px;
  int         mismatch_count = 0;
  bit         sender_gapless = 1'b0;
  int         rx_hold_left   = 0;
  int         stall_span     = 0;
  int         stall_pct      = 0;

  rgb_pixel_color_filter DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_pixel_i  (in_pixel_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_pixel_o (out_pixel_o)
  );

  always #2 clk_i = ~clk_i;

  function automatic pixel_out_t filter_pixel(input pixel_in_t px);
    int ch [3];
    int res [3];
    int acc;
    int peak;
    int lim;
    pixel_out_t po;
    ch[0] = int'(px.red_in);
    ch[1] = int'(px.green_in);
    ch[2] = int'(px.blue_in);
    lim = int'(max_q);
    for (int k = 0; k < 3; k++) res[k] = ch[k];
    case (mode_q)
      FM_GREY: begin
        acc = (LUMA_K[0] * ch[0] + LUMA_K[1] * ch[1] + LUMA_K[2] * ch[2]) >>> 16;
        for (int k = 0; k < 3; k++) res[k] = acc;
      end
      FM_NEGATIVE: begin
        for (int k = 0; k < 3; k++) res[k] = (ch[k] >= lim) ? 0 : lim - ch[k];
      end
      FM_SEPIA: begin
        for (int k = 0; k < 3; k++) begin
          acc = (SEPIA_K[k][0] * ch[0] + SEPIA_K[k][1] * ch[1] +
                 SEPIA_K[k][2] * ch[2]) >>> 16;
          res[k] = (acc >= lim) ? lim : acc;
        end
      end
      FM_TONE: begin
        for (int k = 0; k < 3; k++) begin
          acc = ch[k] + TONE_SHIFT[tone_q][k];
          res[k] = (acc < 0) ? 0 : (acc > 255) ? 255 : acc;
        end
      end
      FM_THRESHOLD: begin
        peak = ch[0];
        if (ch[1] > peak) peak = ch[1];
        if (ch[2] > peak) peak = ch[2];
        for (int k = 0; k < 3; k++) res[k] = (peak > 127) ? 255 : 0;
      end
      default: ;  // pass-through, spare codes included
    endcase
    po.red_out   = res[0][7:0];
    po.green_out = res[1][7:0];
    po.blue_out  = res[2][7:0];
    return po;
  endfunction

  function automatic logic [7:0] pick_channel();
    case ($urandom_range(0, 9))
      0:       return 8'd0;
      1:       return 8'd255;
      2:       return 8'd127;
      3:       return 8'd128;
      4:       return max_q;
      5:       return max_q + 8'd1;
      6:       return max_q - 8'd1;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic pixel_in_t random_pixel();
    pixel_in_t px;
    if ($urandom_range(0, 9) < 6) begin
      px = pixel_in_t'(24'($urandom));
    end else begin
      px.red_in   = pick_channel();
      px.green_in = pick_channel();
      px.blue_in  = pick_channel();
    end
    return px;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    if (mismatch_count < MAX_REPORTS)
      $display("[%0t] mismatch on %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  task automatic add_stimulus(input pixel_in_t px);
    send_queue.insert(send_queue.size(), px);
  endtask

  task automatic add_expected(input pixel_out_t px);
    pending_pixels.insert(pending_pixels.size(), px);
  endtask

  // Output stalls: random duty cycle per span, or a forced long hold-off
  always @(posedge clk_i) begin
    if (rx_hold_left > 0) begin
      out_stall_i  <= 1'b1;
      rx_hold_left <= rx_hold_left - 1;
    end else begin
      if (stall_span == 0) begin
        stall_span <= $urandom_range(8, 120);
        case ($urandom_range(0, 4))
          0, 1:    stall_pct <= 0;
          2:       stall_pct <= 15;
          3:       stall_pct <= 50;
          default: stall_pct <= 85;
        endcase
      end else begin
        stall_span <= stall_span - 1;
      end
      out_stall_i <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // Output checker
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_pixels.size() == 0) begin
        report_mismatch("unexpected pixel", int'(out_pixel_o), 0);
      end else begin
        want_px = pending_pixels.pop_front();
        if (out_pixel_o.red_out !== want_px.red_out)
          report_mismatch("red_out", int'(out_pixel_o.red_out), int'(want_px.red_out));
        if (out_pixel_o.green_out !== want_px.green_out)
          report_mismatch("green_out", int'(out_pixel_o.green_out),
                          int'(want_px.green_out));
        if (out_pixel_o.blue_out !== want_px.blue_out)
          report_mismatch("blue_out", int'(out_pixel_o.blue_out), int'(want_px.blue_out));
      end
    end
  end

  task automatic send_pixel(input pixel_in_t px);
    in_valid_i <= 1'b1;
    in_pixel_i <= px;
    do @(posedge clk_i); while (in_stall_o);
    add_expected(filter_pixel(px));
  endtask

  task automatic send_burst_stream();
    int burst;
    while (send_queue.size() > 0) begin
      burst = $urandom_range(1, 24);
      while (burst > 0 && send_queue.size() > 0) begin
        send_pixel(send_queue.pop_front());
        burst--;
      end
      if (send_queue.size() > 0 && !sender_gapless && $urandom_range(0, 3) != 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end
    end
  endtask

  task automatic drain_pipeline();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_pixels.size() > 0) @(posedge clk_i);
    repeat (PIPE_DEPTH + 2) @(posedge clk_i);
  endtask

  task automatic run_pixels();
    send_burst_stream();
    drain_pipeline();
  endtask

  task automatic queue_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    add_stimulus('{red_in: r, green_in: g, blue_in: b});
  endtask

  // writes all three registers; unused upper data bits carry noise
  task automatic set_config(input logic [MODE_W-1:0] mode, input logic [TONE_W-1:0] tone,
                            input logic [CHANNEL_BITS-1:0] maxv);
    logic [4:0] junk_mode;
    logic [5:0] junk_tone;
    junk_mode = 5'($urandom);
    junk_tone = 6'($urandom);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_FILTER_MODE;
    cfg_wdata_i <= {junk_mode, mode};
    @(posedge clk_i);
    mode_q = mode;
    cfg_idx_i   <= CFG_TONE_SELECT;
    cfg_wdata_i <= {junk_tone, tone};
    @(posedge clk_i);
    tone_q = tone;
    cfg_idx_i   <= CFG_MAX_VALUE;
    cfg_wdata_i <= maxv;
    @(posedge clk_i);
    max_q = maxv;
    cfg_we_i <= 1'b0;
  endtask

  task automatic test_reset_state();
    queue_pixel(8'h00, 8'h00, 8'h00);
    queue_pixel(8'hFF, 8'hFF, 8'hFF);
    queue_pixel(8'hAA, 8'h55, 8'hAA);
    queue_pixel(8'h55, 8'hAA, 8'h55);
    run_pixels();
  endtask

  task automatic test_spare_modes();
    set_config(MODE_SPARE_A, 2'd1, 8'd10);
    queue_pixel(8'h12, 8'h34, 8'h56);
    run_pixels();
    set_config(MODE_SPARE_B, 2'd3, 8'd0);
    queue_pixel(8'hFE, 8'h01, 8'h80);
    run_pixels();
  endtask

  task automatic test_grey();
    set_config(FM_GREY, 2'd0, 8'd255);
    queue_pixel(8'hFF, 8'hFF, 8'hFF);
    queue_pixel(8'h80, 8'hFF, 8'h01);
    run_pixels();
  endtask

  task automatic test_negative();
    set_config(FM_NEGATIVE, 2'd0, 8'd255);
    queue_pixel(8'd0, 8'd255, 8'd1);
    run_pixels();
    // channels at and above the max saturate at zero
    set_config(FM_NEGATIVE, 2'd0, 8'd100);
    queue_pixel(8'd50, 8'd100, 8'd200);
    run_pixels();
    set_config(FM_NEGATIVE, 2'd0, 8'd0);
    queue_pixel(8'd0, 8'd255, 8'd7);
    run_pixels();
  endtask

  task automatic test_sepia();
    set_config(FM_SEPIA, 2'd0, 8'd255);
    queue_pixel(8'hFF, 8'hFF, 8'hFF);
    queue_pixel(8'h10, 8'h20, 8'h30);
    run_pixels();
    set_config(FM_SEPIA, 2'd0, 8'd1);
    queue_pixel(8'h00, 8'h00, 8'h00);
    run_pixels();
    set_config(FM_SEPIA, 2'd0, 8'd0);
    queue_pixel(8'h01, 8'h01, 8'h01);
    run_pixels();
  endtask

  task automatic test_tone();
    set_config(FM_TONE, 2'd0, 8'd255);
    queue_pixel(8'd0, 8'd255, 8'd9);
    run_pixels();
    set_config(FM_TONE, 2'd1, 8'd255);
    queue_pixel(8'd200, 8'd50, 8'd5);
    run_pixels();
    set_config(FM_TONE, 2'd2, 8'd255);
    queue_pixel(8'd100, 8'd255, 8'd30);
    run_pixels();
    set_config(FM_TONE, 2'd3, 8'd255);
    queue_pixel(8'd60, 8'd200, 8'd255);
    run_pixels();
  endtask

  task automatic test_threshold();
    set_config(FM_THRESHOLD, 2'd0, 8'd255);
    queue_pixel(8'd127, 8'd127, 8'd127);
    queue_pixel(8'd10, 8'd200, 8'd200);  // green and blue tie for the max
    queue_pixel(8'd0, 8'd0, 8'd128);
    queue_pixel(8'd128, 8'd0, 8'd0);
    run_pixels();
  endtask

  // long output hold-off while the sender keeps offering, so input stalls
  task automatic test_output_hold();
    set_config(FM_GREY, 2'd0, 8'd255);
    sender_gapless = 1'b1;
    rx_hold_left <= 80;
    repeat (40) add_stimulus(random_pixel());
    run_pixels();
    sender_gapless = 1'b0;
  endtask

  task automatic test_random_phases();
    int sent;
    int phase_len;
    logic [7:0] maxv;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 5))
        0:       maxv = 8'd0;
        1:       maxv = 8'd1;
        2:       maxv = 8'd255;
        default: maxv = 8'($urandom);
      endcase
      set_config(3'($urandom_range(0, 7)), 2'($urandom_range(0, 3)), maxv);
      sender_gapless = ($urandom_range(0, 3) == 0);
      phase_len = $urandom_range(10, 120);
      repeat (phase_len) add_stimulus(random_pixel());
      if ($urandom_range(0, 5) == 0) rx_hold_left <= $urandom_range(20, 60);
      run_pixels();
      sent += phase_len;
    end
    sender_gapless = 1'b0;
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_state();
    test_spare_modes();
    test_grey();
    test_negative();
    test_sepia();
    test_tone();
    test_threshold();
    test_output_hold();
    test_random_phases();
    repeat (PIPE_DEPTH + 4) @(posedge clk_i);
    if (mismatch_count == 0 && pending_pixels.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

`default_nettype wire
